FILE: rtl/tlqwi_pkg.sv
// ----------------------------------------------------------------------------
// tlqwi_pkg: shared types and constants
// Lane depth, field widths, entry layout and the statistics update bundle.
// ----------------------------------------------------------------------------
package tlqwi_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_AW      = PTR_W + 1;          // {lane, slot}

    localparam int ID_W        = 16;
    localparam int TIME_W      = 15;
    localparam int BURST_W     = 4;

    localparam logic [TIME_W-1:0]  DAY_TICKS   = 15'd23040;
    localparam logic [BURST_W-1:0] STREAK_MAX  = 4'd15;
    localparam logic [BURST_W-1:0] BURST_RESET = 4'd3;

    localparam logic OP_JOIN  = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    localparam logic LANE_STD = 1'b0;
    localparam logic LANE_PRI = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   pax_id;
        logic [TIME_W-1:0] join_time;
    } t_entry;

    typedef struct packed {
        logic              serve;
        logic              reject;
        logic [TIME_W-1:0] wait_t;
        logic [CNT_W-1:0]  cnt_pri;
        logic [CNT_W-1:0]  cnt_std;
    } t_stat_upd;

    typedef struct packed {
        logic [31:0]      served;
        logic [39:0]      wait_sum;
        logic [31:0]      rejected;
        logic [CNT_W-1:0] peak_pri;
        logic [CNT_W-1:0] peak_std;
    } t_stats;

    // Result beat, highest bits first; the LSB is op_ok.
    typedef struct packed {
        logic              pad;
        logic [6:0]        peak_standard;
        logic [6:0]        peak_priority;
        logic [31:0]       turned_away_total;
        logic [39:0]       wait_sum;
        logic [31:0]       served_total;
        logic [7:0]        queue_size;
        logic [TIME_W-1:0] wait_time;
        logic              was_priority;
        logic [ID_W-1:0]   pax_out;
        logic              op_ok;
    } t_result;

endpackage

FILE: rtl/tlqwi_ram.sv
// ----------------------------------------------------------------------------
// tlqwi_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlqwi_ram #(
    parameter int AW = 7,
    parameter int DW = 31
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tlqwi_stats.sv
// ----------------------------------------------------------------------------
// tlqwi_stats: saturating statistics
// Served count, wait sum, turn-away count and per-lane occupancy peaks.
// ----------------------------------------------------------------------------
module tlqwi_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlqwi_pkg::t_stat_upd i_upd,
    output tlqwi_pkg::t_stats    o_next
);
    import tlqwi_pkg::*;

    t_stats      r_stats;
    t_stats      n_stats;
    logic [40:0] sum_ext;

    always_comb begin
        n_stats = r_stats;
        sum_ext = {1'b0, r_stats.wait_sum} + 41'(i_upd.wait_t);
        if (i_upd.serve) begin
            if (r_stats.served != '1) begin
                n_stats.served = r_stats.served + 32'd1;
            end
            n_stats.wait_sum = sum_ext[40] ? '1 : sum_ext[39:0];
        end
        if (i_upd.reject && (r_stats.rejected != '1)) begin
            n_stats.rejected = r_stats.rejected + 32'd1;
        end
        // counts only grow by pushes, so tracking the max every cycle is enough
        if (i_upd.cnt_pri > r_stats.peak_pri) begin
            n_stats.peak_pri = i_upd.cnt_pri;
        end
        if (i_upd.cnt_std > r_stats.peak_std) begin
            n_stats.peak_std = i_upd.cnt_std;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats <= '0;
        end else begin
            r_stats <= n_stats;
        end
    end

    assign o_next = n_stats;

endmodule

FILE: rtl/two_lane_queue_weighted_interleave_unit.sv
// Results: a join beat yields its result in the output register at the accept edge
//   (visible the next cycle); a serve beat first reads the entry RAM, then loads
//   the output register from state POP. No new beat is taken while a serve is in
//   flight on the shared entry RAM. Both need a free output slot.
// Reset (synchronous, active low): lanes empty, streak and statistics zero,
//   burst_limit 3. The entry RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// two_lane_queue_weighted_interleave_unit: two FIFO lanes, weighted arbiter
// Priority and standard lanes share one entry RAM addressed {lane, slot}.
// Serves favor priority for up to burst_limit beats in a row, then one standard.
// ----------------------------------------------------------------------------
module two_lane_queue_weighted_interleave_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: burst_limit
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [15:0] pax_id, [30:16] now_time, [31] zero
    input  logic [1:0]   s_axis_tuser,   // [0] opcode, [1] priority_lane
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // [0] op_ok, [16:1] pax_out, [17] was_priority,
                                         // [32:18] wait_time, [40:33] queue_size,
                                         // [72:41] served_total, [112:73] wait_sum,
                                         // [144:113] turned_away_total,
                                         // [151:145] peak_priority,
                                         // [158:152] peak_standard, [159] zero
);
    import tlqwi_pkg::*;

    // Controller: IDLE takes beats, POP finishes a serve once RAM data is back.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic               r_state, n_state;
    logic [PTR_W-1:0]   r_head [2];
    logic [PTR_W-1:0]   n_head [2];
    logic [PTR_W-1:0]   r_tail [2];
    logic [PTR_W-1:0]   n_tail [2];
    logic [CNT_W-1:0]   r_cnt  [2];
    logic [CNT_W-1:0]   n_cnt  [2];
    logic [BURST_W-1:0] r_streak, n_streak;
    logic [BURST_W-1:0] r_burst;
    logic               r_take, n_take;      // lane of the serve in flight
    logic [TIME_W-1:0]  r_now, n_now;        // serve time of the serve in flight

    logic               r_out_valid;
    t_result            r_out;

    // input beat fields
    logic               in_op;
    logic               in_lane;
    logic [ID_W-1:0]    in_pax;
    logic [TIME_W-1:0]  in_now;
    logic               accept;
    logic               out_free;

    // arbitration
    logic               pri_has, std_has, any_item, take;
    logic [CNT_W-1:0]   cnt_sel;
    logic               lane_full;
    logic [PTR_W-1:0]   tail_sel, head_take;

    // RAM ports
    logic               ram_we, ram_re;
    logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
    t_entry             ram_wdata, ram_rdata;

    // result assembly
    logic               out_load;
    logic               res_ok, res_wasp;
    logic [ID_W-1:0]    res_pax;
    logic [TIME_W-1:0]  res_wait;
    logic [TIME_W-1:0]  wait_raw;

    t_stat_upd          upd;
    t_stats             stats_next;

    assign in_op   = s_axis_tuser[0];
    assign in_lane = s_axis_tuser[1];
    assign in_pax  = s_axis_tdata[15:0];
    assign in_now  = s_axis_tdata[30:16];

    // A result beat may enter the output register if it is empty or drains now.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Weighted pick: the only nonempty lane, else priority while streak < burst_limit.
    assign pri_has   = (r_cnt[1] != '0);
    assign std_has   = (r_cnt[0] != '0);
    assign any_item  = pri_has || std_has;
    assign take      = pri_has && (!std_has || (r_streak < r_burst));

    assign cnt_sel   = in_lane ? r_cnt[1] : r_cnt[0];
    assign lane_full = (cnt_sel == CNT_W'(QUEUE_DEPTH));
    assign tail_sel  = in_lane ? r_tail[1] : r_tail[0];
    assign head_take = take ? r_head[1] : r_head[0];

    // Wait with midnight wrap, kept to 15 bits.
    always_comb begin
        wait_raw = r_now - ram_rdata.join_time;
        if (r_now < ram_rdata.join_time) begin
            wait_raw = wait_raw + DAY_TICKS;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_streak = r_streak;
        n_take   = r_take;
        n_now    = r_now;
        for (int i = 0; i < 2; i++) begin
            n_head[i] = r_head[i];
            n_tail[i] = r_tail[i];
            n_cnt[i]  = r_cnt[i];
        end

        ram_we           = 1'b0;
        ram_waddr        = {in_lane, tail_sel};
        ram_wdata.pax_id = in_pax;
        ram_wdata.join_time = in_now;
        ram_re           = 1'b0;
        ram_raddr        = {take, head_take};

        out_load = 1'b0;
        res_ok   = 1'b0;
        res_wasp = 1'b0;
        res_pax  = '0;
        res_wait = '0;

        upd.serve  = 1'b0;
        upd.reject = 1'b0;
        upd.wait_t = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_JOIN) begin
                        out_load = 1'b1;
                        if (lane_full) begin
                            upd.reject = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            res_ok = 1'b1;
                            for (int i = 0; i < 2; i++) begin
                                if (in_lane == 1'(i)) begin
                                    n_tail[i] = (r_tail[i] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                '0 : r_tail[i] + 1'b1;
                                    n_cnt[i]  = r_cnt[i] + 1'b1;
                                end
                            end
                        end
                    end else if (any_item) begin
                        // pop now, result once the RAM read returns
                        ram_re  = 1'b1;
                        n_take  = take;
                        n_now   = in_now;
                        n_state = S_POP;
                        for (int i = 0; i < 2; i++) begin
                            if (take == 1'(i)) begin
                                n_head[i] = (r_head[i] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : r_head[i] + 1'b1;
                                n_cnt[i]  = r_cnt[i] - 1'b1;
                            end
                        end
                        if (take == LANE_PRI) begin
                            if (r_streak != STREAK_MAX) begin
                                n_streak = r_streak + 1'b1;
                            end
                        end else begin
                            n_streak = '0;
                        end
                    end else begin
                        // serve on empty lanes: zero op_ok, pax_out and wait_time, nothing changes
                        out_load = 1'b1;
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    res_ok     = 1'b1;
                    res_wasp   = r_take;
                    res_pax    = ram_rdata.pax_id;
                    res_wait   = wait_raw;
                    upd.serve  = 1'b1;
                    upd.wait_t = wait_raw;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        upd.cnt_pri = n_cnt[1];
        upd.cnt_std = n_cnt[0];
    end

    tlqwi_ram #(
        .AW (RAM_AW),
        .DW ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tlqwi_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_next  (stats_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_streak <= '0;
            r_burst  <= BURST_RESET;
            for (int i = 0; i < 2; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_streak <= n_streak;
            if (i_cfg_we) begin
                r_burst <= i_cfg_wdata;
            end
            for (int i = 0; i < 2; i++) begin
                r_head[i] <= n_head[i];
                r_tail[i] <= n_tail[i];
                r_cnt[i]  <= n_cnt[i];
            end
        end
    end

    // serve context, no reset needed
    always_ff @(posedge i_clk) begin
        r_take <= n_take;
        r_now  <= n_now;
    end

    // Output register: holds a result beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pad               <= 1'b0;
            r_out.peak_standard     <= 7'(stats_next.peak_std);
            r_out.peak_priority     <= 7'(stats_next.peak_pri);
            r_out.turned_away_total <= stats_next.rejected;
            r_out.wait_sum          <= stats_next.wait_sum;
            r_out.served_total      <= stats_next.served;
            r_out.queue_size        <= 8'(n_cnt[0]) + 8'(n_cnt[1]);
            r_out.wait_time         <= res_wait;
            r_out.was_priority      <= res_wasp;
            r_out.pax_out           <= res_pax;
            r_out.op_ok             <= res_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    // lane occupancy never passes the lane depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CNT_W'(QUEUE_DEPTH)) && (r_cnt[1] <= CNT_W'(QUEUE_DEPTH)))
        else $error("lane count above depth");

    // tail stays head plus count, modulo depth, in both lanes
    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((int'(r_head[0]) + int'(r_cnt[0])) % QUEUE_DEPTH) == int'(r_tail[0])) &&
        (((int'(r_head[1]) + int'(r_cnt[1])) % QUEUE_DEPTH) == int'(r_tail[1])))
        else $error("lane pointers and count disagree");

    // a serve on a nonempty queue must go finish its pop
    a_serve_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op == OP_SERVE) && any_item) |=> (r_state == S_POP))
        else $error("serve did not enter pop");

    // a serve in flight blocks new beats, so RAM reads and writes never meet
    a_pop_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (!accept && !ram_we))
        else $error("beat taken during pop");
`endif

endmodule

FILE: bench/two_lane_queue_weighted_interleave_unit_test.sv
// ----------------------------------------------------------------------------
// two_lane_queue_weighted_interleave_unit_test: self-checking stream bench
// Drives join and serve beats into the two-lane queue, predicts every result
// beat with an in-bench lane model and compares each field on the way out.
// ----------------------------------------------------------------------------
module two_lane_queue_weighted_interleave_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tlqwi_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // watchdog bound on the whole run
    localparam int REPORT_LIMIT = 10;

    // One request beat as the bench sees it.
    typedef struct {
        logic              op;
        logic [ID_W-1:0]   pax_id;
        logic              lane;
        logic [TIME_W-1:0] now_time;
    } t_request;

    // One waiting entry in a modeled lane.
    typedef struct {
        logic [ID_W-1:0]   pax_id;
        logic [TIME_W-1:0] join_time;
    } t_waiting;

    // ---------------------------------------------------------------- DUT I/O
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [3:0]   i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;   // [15:0] pax_id, [30:16] now_time, [31] zero
    logic [1:0]   s_axis_tuser  = '0;   // [0] opcode, [1] priority_lane
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;         // see t_result, op_ok in bit 0

    two_lane_queue_weighted_interleave_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------ lane model
    // Lane queues indexed by LANE_STD / LANE_PRI, plus the arbiter streak and
    // the saturating statistics, all mirrored at the block's widths.
    t_waiting     lane_q[2][$];
    int           lane_peak[2];
    logic [3:0]   streak        = '0;
    logic [3:0]   burst_limit   = BURST_RESET;
    logic [31:0]  served_cnt    = '0;
    logic [39:0]  wait_acc      = '0;
    logic [31:0]  rejected_cnt  = '0;

    // Request beats waiting to be driven, and results owed by the block.
    t_request     queued_requests[$];
    t_result      owed_results[$];
    t_request     cur_req;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           mismatches    = 0;
    int           cycles        = 0;

    // Apply one accepted beat to the lane model and return its result beat.
    function automatic t_result serve_or_join(input t_request r);
        t_result  res;
        t_waiting head;
        logic     take;
        int       gap;
        logic [40:0] sum;
        res = '0;
        if (r.op == OP_JOIN) begin
            if (lane_q[r.lane].size() >= QUEUE_DEPTH) begin
                // full lane: beat dropped, turn-away counted
                if (rejected_cnt != 32'hFFFF_FFFF) rejected_cnt++;
            end else begin
                head.pax_id    = r.pax_id;
                head.join_time = r.now_time;
                lane_q[r.lane].push_back(head);
                if (lane_q[r.lane].size() > lane_peak[r.lane])
                    lane_peak[r.lane] = lane_q[r.lane].size();
                res.op_ok = 1'b1;
            end
        end else if (lane_q[LANE_PRI].size() + lane_q[LANE_STD].size() != 0) begin
            // one lane empty: take the other; both busy: weighted choice
            if (lane_q[LANE_PRI].size() == 0)
                take = LANE_STD;
            else if (lane_q[LANE_STD].size() == 0)
                take = LANE_PRI;
            else
                take = (streak < burst_limit) ? LANE_PRI : LANE_STD;
            head = lane_q[take].pop_front();

            // wait with midnight wrap, kept to 15 bits
            gap = int'(r.now_time) - int'(head.join_time);
            if (r.now_time < head.join_time) gap += int'(DAY_TICKS);

            if (take == LANE_PRI) begin
                if (streak < STREAK_MAX) streak++;
            end else begin
                streak = '0;
            end
            if (served_cnt != 32'hFFFF_FFFF) served_cnt++;
            sum = {1'b0, wait_acc} + 41'(gap[TIME_W-1:0]);
            wait_acc = sum[40] ? 40'hFF_FFFF_FFFF : sum[39:0];

            res.op_ok        = 1'b1;
            res.pax_out      = head.pax_id;
            res.was_priority = take;
            res.wait_time    = gap[TIME_W-1:0];
        end
        // empty serve leaves streak alone and reports zero op_ok, pax_out and wait_time
        res.queue_size        = 8'(lane_q[LANE_PRI].size() + lane_q[LANE_STD].size());
        res.served_total      = served_cnt;
        res.wait_sum          = wait_acc;
        res.turned_away_total = rejected_cnt;
        res.peak_priority     = 7'(lane_peak[LANE_PRI]);
        res.peak_standard     = 7'(lane_peak[LANE_STD]);
        return res;
    endfunction

    // -------------------------------------------------------------- driver
    // Holds the beat until tready; predicts at the accept edge, then loads the
    // next request unless the sender decides to idle this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                owed_results.push_back(serve_or_join(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (queued_requests.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_req = queued_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, cur_req.now_time, cur_req.pax_id};
                    s_axis_tuser  <= {cur_req.lane, cur_req.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------- monitor
    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h got %0h",
                         $realtime, fname, want, seen);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing owed, got %0h",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = owed_results.pop_front();
                    check_field("op_ok", 64'(want.op_ok), 64'(seen.op_ok));
                    check_field("pax_out", 64'(want.pax_out), 64'(seen.pax_out));
                    check_field("was_priority", 64'(want.was_priority),
                                64'(seen.was_priority));
                    check_field("wait_time", 64'(want.wait_time), 64'(seen.wait_time));
                    check_field("queue_size", 64'(want.queue_size), 64'(seen.queue_size));
                    check_field("served_total", 64'(want.served_total),
                                64'(seen.served_total));
                    check_field("wait_sum", 64'(want.wait_sum), 64'(seen.wait_sum));
                    check_field("turned_away_total", 64'(want.turned_away_total),
                                64'(seen.turned_away_total));
                    check_field("peak_priority", 64'(want.peak_priority),
                                64'(seen.peak_priority));
                    check_field("peak_standard", 64'(want.peak_standard),
                                64'(seen.peak_standard));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // -------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------ stimulus
    function automatic t_request make_req(input logic op, input logic lane,
                                          input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] now);
        t_request r;
        r.op       = op;
        r.lane     = lane;
        r.pax_id   = id;
        r.now_time = now;
        return r;
    endfunction

    // Random content; one time stamp in ten lands past the end of the day.
    function automatic t_request rand_req(input logic op, input logic lane);
        logic [TIME_W-1:0] now;
        now = ($urandom_range(9) == 0) ? TIME_W'($urandom_range(32767, 23040))
                                       : TIME_W'($urandom_range(23039));
        return make_req(op, lane, ID_W'($urandom_range(65535)), now);
    endfunction

    // Block until every queued beat went in and every owed result came out.
    task automatic drain_outstanding();
        while (queued_requests.size() != 0 || s_axis_tvalid ||
               owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write only with the block idle, after every queued beat went in and
    // every owed result came out.
    task automatic write_burst_limit(input logic [3:0] value);
        drain_outstanding();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        burst_limit  = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mix of well-formed runs: lane fills past full, priority-heavy fills
    // that make the burst limit bite, drains that run into empty, and noise.
    task automatic queue_random_phase(input int count);
        int made;
        int run;
        int join_pct;
        int shape;
        logic lane;
        made = 0;
        while (made < count) begin
            shape = $urandom_range(99);
            run   = 0;
            if (shape < 20) begin
                lane = 1'($urandom_range(1));
                run  = $urandom_range(75, 55);
                for (int k = 0; k < run; k++)
                    queued_requests.push_back(rand_req(OP_JOIN, lane));
            end else if (shape < 35) begin
                run = $urandom_range(60, 30);
                for (int k = 0; k < run; k++)
                    queued_requests.push_back(rand_req(OP_JOIN,
                        ($urandom_range(99) < 75) ? LANE_PRI : LANE_STD));
            end else if (shape < 50) begin
                run = $urandom_range(80, 20);
                for (int k = 0; k < run; k++)
                    queued_requests.push_back(rand_req(OP_SERVE,
                                                       1'($urandom_range(1))));
            end else begin
                run      = $urandom_range(40, 10);
                join_pct = $urandom_range(75, 25);
                for (int k = 0; k < run; k++)
                    queued_requests.push_back(rand_req(
                        ($urandom_range(99) < join_pct) ? OP_JOIN : OP_SERVE,
                        1'($urandom_range(1))));
            end
            made += run;
        end
    endtask

    initial begin
        logic [3:0] phase_limits[6];
        phase_limits = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd7, 4'($urandom_range(14, 2))};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset burst limit: empty serve, extreme ids and
        // times, midnight wrap from both sides, forced standard after a
        // priority streak, and a final serve on empty lanes.
        queued_requests.push_back(make_req(OP_SERVE, LANE_STD, 16'h0000, 15'd0));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_PRI, 16'hFFFF, 15'h7FFF));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_STD, 16'h0000, 15'd0));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_PRI, 16'h0001, 15'd23039));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_STD, 16'hAAAA, 15'd100));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_PRI, 16'h5555, 15'd5));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_PRI, 16'h1234, 15'd12000));
        queued_requests.push_back(make_req(OP_JOIN,  LANE_PRI, 16'h8000, 15'h4000));
        queued_requests.push_back(make_req(OP_SERVE, LANE_PRI, 16'h0000, 15'd0));
        queued_requests.push_back(make_req(OP_SERVE, LANE_STD, 16'hFFFF, 15'd23039));
        queued_requests.push_back(make_req(OP_SERVE, LANE_PRI, 16'h0000, 15'd3));
        queued_requests.push_back(make_req(OP_SERVE, LANE_STD, 16'h0000, 15'd200));
        queued_requests.push_back(make_req(OP_SERVE, LANE_PRI, 16'h0000, 15'h7FFF));
        queued_requests.push_back(make_req(OP_SERVE, LANE_PRI, 16'h0000, 15'h2000));
        queued_requests.push_back(make_req(OP_SERVE, LANE_STD, 16'h0000, 15'd50));
        queued_requests.push_back(make_req(OP_SERVE, LANE_PRI, 16'h0000, 15'h7FFF));

        // Six random phases, each under its own burst limit; the first pair
        // holds back the receiver, the second holds back the sender, the last pair
        // runs at full rate.
        for (int p = 0; p < 6; p++) begin
            write_burst_limit(phase_limits[p]);
            send_idle_pct = (p < 2) ? 17 : (p < 4) ? 81 : 0;
            recv_idle_pct = (p < 2) ? 81 : (p < 4) ? 17 : 0;
            queue_random_phase(315);
        end

        drain_outstanding();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
